[rtl/thin_multipole_kick_unit_defines.svh]
// ----------------------------------------------------------------------------
// thin multipole kick unit assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef THIN_MULTIPOLE_KICK_UNIT_DEFINES_SVH
`define THIN_MULTIPOLE_KICK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TMK_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tmk check failed: same-cycle implication");
// next-cycle implication
`define TMK_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tmk check failed: next-cycle implication");
`else
`define TMK_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define TMK_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

[rtl/tmk_pkg.sv]
// ----------------------------------------------------------------------------
// tmk_pkg
// shared types and constants of the thin multipole kick unit
// ----------------------------------------------------------------------------
`default_nettype none

package tmk_pkg;

    localparam int DATA_W        = 32;
    localparam int ORD_FIELD_W   = 5;
    localparam int MODE_W        = 2;
    localparam int APB_ADDR_W    = 4;
    localparam int MAX_ORDER_DEF = 16;
    localparam int FRAC_BITS_DEF = 24;

    // kick modes
    localparam logic [MODE_W-1:0] MODE_DIPOLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPOUND = 2'd2;

    // request types
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_KICK = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_KICK_SCALE = 2'd0;
    localparam logic [1:0] REG_KICK_MODE  = 2'd1;
    localparam logic [1:0] REG_POLE_POWER = 2'd2;
    localparam logic [1:0] REG_TOP_ORDER  = 2'd3;

    // complex multiply issued to the datapath
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_POW,
        MUL_COEF,
        MUL_SCALE
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIP,
        ST_MP,
        ST_MPW,
        ST_COEF,
        ST_CPOW,
        ST_CACC,
        ST_SCALE,
        ST_SWAIT,
        ST_FIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    table_wr;
        mul_op_t mul_op;
        logic    scale_src_pow;
        logic    acc_en;
        logic    fin_en;
        logic    dip_en;
        logic    push;
    } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/tmk_ctrl.sv]
// ----------------------------------------------------------------------------
// tmk_ctrl
// sequencer of the kick unit: handshakes, order counter, datapath commands
// ----------------------------------------------------------------------------
`default_nettype none

module tmk_ctrl #(
    parameter int MAX_ORDER = tmk_pkg::MAX_ORDER_DEF,
    localparam int IDX_W    = $clog2(MAX_ORDER + 1)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_req_type,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    input  wire logic [tmk_pkg::MODE_W-1:0]      kick_mode,
    input  wire logic [tmk_pkg::ORD_FIELD_W-1:0] pole_power,
    input  wire logic [tmk_pkg::ORD_FIELD_W-1:0] top_order,
    input  wire logic                            scale_zero,
    output tmk_pkg::dp_cmd_t                     cmd,
    output logic [IDX_W-1:0]                     coef_sel
);

    function automatic logic [IDX_W-1:0] clamp_order(
        input logic [tmk_pkg::ORD_FIELD_W-1:0] v
    );
        logic [IDX_W-1:0] r;
        if (v == '0) begin
            r = IDX_W'(1);
        end else if (32'(v) > 32'(MAX_ORDER)) begin
            r = IDX_W'(MAX_ORDER);
        end else begin
            r = IDX_W'(v);
        end
        return r;
    endfunction

    tmk_pkg::ctrl_state_t state_reg, state_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     n_sel;
    logic                 k_less;
    logic                 accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tmk_pkg::ST_IDLE;
            k_reg         <= IDX_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready  = (state_reg == tmk_pkg::ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign accept   = s_valid && s_ready;
    assign n_sel    = (kick_mode == tmk_pkg::MODE_SINGLE) ? clamp_order(pole_power)
                                                          : clamp_order(top_order);
    assign k_less   = (k_reg < n_sel);
    assign coef_sel = k_reg;

    always_comb begin
        state_next        = state_reg;
        k_next            = k_reg;
        cmd               = '0;
        cmd.mul_op        = tmk_pkg::MUL_NONE;
        cmd.scale_src_pow = (kick_mode == tmk_pkg::MODE_SINGLE);
        out_valid_next    = m_ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            tmk_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == tmk_pkg::REQ_KICK) begin
                        cmd.load = 1'b1;
                        k_next   = IDX_W'(1);
                        if (scale_zero) begin
                            state_next = tmk_pkg::ST_DONE;
                        end else begin
                            case (kick_mode)
                                tmk_pkg::MODE_DIPOLE:   state_next = tmk_pkg::ST_DIP;
                                tmk_pkg::MODE_SINGLE:   state_next = tmk_pkg::ST_MP;
                                tmk_pkg::MODE_COMPOUND: state_next = tmk_pkg::ST_COEF;
                                default:                state_next = tmk_pkg::ST_DONE;
                            endcase
                        end
                    end else begin
                        cmd.table_wr = 1'b1;
                    end
                end
            end
            tmk_pkg::ST_DIP: begin
                cmd.dip_en = 1'b1;
                state_next = tmk_pkg::ST_DONE;
            end
            // single multipole: each power step multiplies in ST_MP, then advances the order in ST_MPW
            tmk_pkg::ST_MP: begin
                if (k_less) begin
                    cmd.mul_op = tmk_pkg::MUL_POW;
                    state_next = tmk_pkg::ST_MPW;
                end else begin
                    state_next = tmk_pkg::ST_SCALE;
                end
            end
            tmk_pkg::ST_MPW: begin
                k_next     = k_reg + IDX_W'(1);
                state_next = tmk_pkg::ST_MP;
            end
            // compound: coefficient term, next power, accumulate
            tmk_pkg::ST_COEF: begin
                cmd.mul_op = tmk_pkg::MUL_COEF;
                state_next = tmk_pkg::ST_CPOW;
            end
            tmk_pkg::ST_CPOW: begin
                if (k_less) begin
                    cmd.mul_op = tmk_pkg::MUL_POW;
                end
                state_next = tmk_pkg::ST_CACC;
            end
            tmk_pkg::ST_CACC: begin
                cmd.acc_en = 1'b1;
                if (k_less) begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = tmk_pkg::ST_COEF;
                end else begin
                    state_next = tmk_pkg::ST_SCALE;
                end
            end
            tmk_pkg::ST_SCALE: begin
                cmd.mul_op = tmk_pkg::MUL_SCALE;
                state_next = tmk_pkg::ST_SWAIT;
            end
            tmk_pkg::ST_SWAIT: begin
                state_next = tmk_pkg::ST_FIN;
            end
            tmk_pkg::ST_FIN: begin
                cmd.fin_en = 1'b1;
                state_next = tmk_pkg::ST_DONE;
            end
            tmk_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.push       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = tmk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tmk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/tmk_dp.sv]
// ----------------------------------------------------------------------------
// tmk_dp
// fixed-point datapath: coefficient table, complex multiplier, accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module tmk_dp #(
    parameter int MAX_ORDER = tmk_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = tmk_pkg::FRAC_BITS_DEF,
    localparam int IDX_W    = $clog2(MAX_ORDER + 1),
    localparam int DEPTH    = MAX_ORDER + 1
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire tmk_pkg::dp_cmd_t                 cmd,
    input  wire logic [IDX_W-1:0]                 coef_sel,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] kick_scale,
    input  wire logic [tmk_pkg::ORD_FIELD_W-1:0]  s_coef_index,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_coef_real,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_coef_imag,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_pos_x,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_pos_y,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_mom_x,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_mom_y,
    output logic signed [tmk_pkg::DATA_W-1:0]     m_new_mom_x,
    output logic signed [tmk_pkg::DATA_W-1:0]     m_new_mom_y,
    output logic                                  m_saturated
);

    localparam int DW = tmk_pkg::DATA_W;
    localparam int PW = 2 * DW;
    localparam int WW = PW + 1;

    // saturate a wide signed value to 32 bits, msb of result is the overflow flag
    function automatic logic [DW:0] sat_fn(input logic signed [WW-1:0] v);
        logic [DW:0] r;
        if (v[WW-1:DW-1] == '0 || v[WW-1:DW-1] == '1) begin
            r = {1'b0, v[DW-1:0]};
        end else if (v[WW-1]) begin
            r = {1'b1, 1'b1, {(DW-1){1'b0}}};
        end else begin
            r = {1'b1, 1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [WW-1:0] ext(input logic signed [DW-1:0] v);
        return {{(WW-DW){v[DW-1]}}, v};
    endfunction

    // coefficient table, cleared at reset
    logic signed [DW-1:0] coef_re_reg [DEPTH];
    logic signed [DW-1:0] coef_im_reg [DEPTH];
    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_widx;

    assign tbl_we   = cmd.table_wr && ({27'd0, s_coef_index} <= 32'(MAX_ORDER));
    assign tbl_widx = IDX_W'(s_coef_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                coef_re_reg[i] <= '0;
                coef_im_reg[i] <= '0;
            end
        end else if (tbl_we) begin
            coef_re_reg[tbl_widx] <= s_coef_real;
            coef_im_reg[tbl_widx] <= s_coef_imag;
        end
    end

    // working registers
    logic signed [DW-1:0] z_r_reg, z_i_reg;
    logic signed [DW-1:0] p_r_reg, p_i_reg, p_r_next, p_i_next;
    logic signed [DW-1:0] acc_r_reg, acc_i_reg, acc_r_next, acc_i_next;
    logic signed [DW-1:0] term_r_reg, term_i_reg, term_r_next, term_i_next;
    logic signed [DW-1:0] sc_r_reg, sc_i_reg, sc_r_next, sc_i_next;
    logic signed [DW-1:0] nx_reg, ny_reg, nx_next, ny_next;
    logic                 flag_reg, flag_next;
    logic signed [DW-1:0] out_x_reg, out_y_reg, out_x_next, out_y_next;
    logic                 out_sat_reg, out_sat_next;

    // multiplier stage
    logic signed [DW-1:0] op_a [4];
    logic signed [DW-1:0] op_b [4];
    logic signed [PW-1:0] prod_next [4];
    logic signed [PW-1:0] prod_reg [4];
    tmk_pkg::mul_op_t     tag_reg;

    // combine stage
    logic signed [PW-1:0] sh [4];
    logic signed [WW-1:0] cre, cim;
    logic [DW:0]          re_s, im_s, acc_rs, acc_is, fin_xs, fin_ys, dip_s;
    logic signed [DW-1:0] src_r, src_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= tmk_pkg::MUL_NONE;
        end else begin
            tag_reg <= cmd.mul_op;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            prod_reg[i] <= prod_next[i];
        end
        if (cmd.load) begin
            z_r_reg <= s_pos_x;
            z_i_reg <= s_pos_y;
        end
        p_r_reg     <= p_r_next;
        p_i_reg     <= p_i_next;
        acc_r_reg   <= acc_r_next;
        acc_i_reg   <= acc_i_next;
        term_r_reg  <= term_r_next;
        term_i_reg  <= term_i_next;
        sc_r_reg    <= sc_r_next;
        sc_i_reg    <= sc_i_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        flag_reg    <= flag_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_sat_reg <= out_sat_next;
    end

    assign src_r = cmd.scale_src_pow ? p_r_reg : acc_r_reg;
    assign src_i = cmd.scale_src_pow ? p_i_reg : acc_i_reg;

    // operand select: products are ar*br, ai*bi, ar*bi, ai*br
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            op_a[i] = '0;
            op_b[i] = '0;
        end
        case (cmd.mul_op)
            tmk_pkg::MUL_POW: begin
                op_a[0] = p_r_reg; op_b[0] = z_r_reg;
                op_a[1] = p_i_reg; op_b[1] = z_i_reg;
                op_a[2] = p_r_reg; op_b[2] = z_i_reg;
                op_a[3] = p_i_reg; op_b[3] = z_r_reg;
            end
            tmk_pkg::MUL_COEF: begin
                op_a[0] = coef_re_reg[coef_sel]; op_b[0] = p_r_reg;
                op_a[1] = coef_im_reg[coef_sel]; op_b[1] = p_i_reg;
                op_a[2] = coef_re_reg[coef_sel]; op_b[2] = p_i_reg;
                op_a[3] = coef_im_reg[coef_sel]; op_b[3] = p_r_reg;
            end
            tmk_pkg::MUL_SCALE: begin
                op_a[0] = kick_scale; op_b[0] = src_r;
                op_a[2] = kick_scale; op_b[2] = src_i;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            prod_next[i] = op_a[i] * op_b[i];
        end
    end

    // floor shift, complex combine, saturations
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sh[i] = prod_reg[i] >>> FRAC_BITS;
        end
        cre    = {sh[0][PW-1], sh[0]} - {sh[1][PW-1], sh[1]};
        cim    = {sh[2][PW-1], sh[2]} + {sh[3][PW-1], sh[3]};
        re_s   = sat_fn(cre);
        im_s   = sat_fn(cim);
        acc_rs = sat_fn(ext(acc_r_reg) + ext(term_r_reg));
        acc_is = sat_fn(ext(acc_i_reg) + ext(term_i_reg));
        fin_xs = sat_fn(ext(nx_reg) - ext(sc_r_reg));
        fin_ys = sat_fn(ext(ny_reg) + ext(sc_i_reg));
        dip_s  = sat_fn(ext(nx_reg) - ext(kick_scale));
    end

    always_comb begin
        p_r_next     = p_r_reg;
        p_i_next     = p_i_reg;
        acc_r_next   = acc_r_reg;
        acc_i_next   = acc_i_reg;
        term_r_next  = term_r_reg;
        term_i_next  = term_i_reg;
        sc_r_next    = sc_r_reg;
        sc_i_next    = sc_i_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        flag_next    = flag_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_sat_next = out_sat_reg;

        case (tag_reg)
            tmk_pkg::MUL_POW: begin
                p_r_next  = re_s[DW-1:0];
                p_i_next  = im_s[DW-1:0];
                flag_next = flag_next | re_s[DW] | im_s[DW];
            end
            tmk_pkg::MUL_COEF: begin
                term_r_next = re_s[DW-1:0];
                term_i_next = im_s[DW-1:0];
                flag_next   = flag_next | re_s[DW] | im_s[DW];
            end
            tmk_pkg::MUL_SCALE: begin
                sc_r_next = re_s[DW-1:0];
                sc_i_next = im_s[DW-1:0];
                flag_next = flag_next | re_s[DW] | im_s[DW];
            end
            default: begin
            end
        endcase

        if (cmd.acc_en) begin
            acc_r_next = acc_rs[DW-1:0];
            acc_i_next = acc_is[DW-1:0];
            flag_next  = flag_next | acc_rs[DW] | acc_is[DW];
        end
        if (cmd.fin_en) begin
            nx_next   = fin_xs[DW-1:0];
            ny_next   = fin_ys[DW-1:0];
            flag_next = flag_next | fin_xs[DW] | fin_ys[DW];
        end
        if (cmd.dip_en) begin
            nx_next   = dip_s[DW-1:0];
            flag_next = flag_next | dip_s[DW];
        end
        if (cmd.load) begin
            p_r_next   = s_pos_x;
            p_i_next   = s_pos_y;
            acc_r_next = '0;
            acc_i_next = '0;
            nx_next    = s_mom_x;
            ny_next    = s_mom_y;
            flag_next  = 1'b0;
        end
        if (cmd.push) begin
            out_x_next   = nx_reg;
            out_y_next   = ny_reg;
            out_sat_next = flag_reg;
        end
    end

    assign m_new_mom_x = out_x_reg;
    assign m_new_mom_y = out_y_reg;
    assign m_saturated = out_sat_reg;

endmodule

`default_nettype wire

[rtl/thin_multipole_kick_unit.sv]
// ----------------------------------------------------------------------------
// thin_multipole_kick_unit
// thin-lens multipole kick on one particle, Q8.24 fixed point
// ----------------------------------------------------------------------------
// Each kick request takes z = pos_x + i*pos_y and returns new momenta: dipole
// mode subtracts kick_scale from mom_x, single multipole mode raises z to
// pole_power, compound mode sums coef[n]*z^n for n = 1..top_order, and both
// multipole modes then subtract scale*Re from mom_x and add scale*Im to mom_y.
// Load requests (req_type 0) write one complex coefficient and return nothing.
// All products are floored Q8.24 and every intermediate saturates to 32 bits,
// raising m_saturated. One request is worked on at a time; the single
// four-multiplier complex unit forms each complex product in two steps
// (multiply, then shift/combine/saturate), and compound mode works each order
// through the coefficient term, the next power and the running sum. Load
// requests leave the unit idle, so s_ready stays high. A finished result waits
// in an output register, so the next request is accepted while it is still
// pending.
// Registers (apb, word addresses): 0x0 kick_scale, 0x4 kick_mode,
// 0x8 pole_power, 0xc top_order; write only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thin_multipole_kick_unit_defines.svh"

module thin_multipole_kick_unit #(
    parameter int MAX_ORDER = tmk_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = tmk_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tmk_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tmk_pkg::DATA_W-1:0]        pwdata,
    output logic [tmk_pkg::DATA_W-1:0]             prdata,
    output logic                                   pready,
    // request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_req_type,
    input  wire logic [tmk_pkg::ORD_FIELD_W-1:0]   s_coef_index,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_coef_real,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_coef_imag,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_pos_x,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_pos_y,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_mom_x,
    input  wire logic signed [tmk_pkg::DATA_W-1:0] s_mom_y,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [tmk_pkg::DATA_W-1:0]      m_new_mom_x,
    output logic signed [tmk_pkg::DATA_W-1:0]      m_new_mom_y,
    output logic                                   m_saturated
);

    localparam int IDX_W = $clog2(MAX_ORDER + 1);

    // configuration registers
    logic signed [tmk_pkg::DATA_W-1:0]  kick_scale_reg, kick_scale_next;
    logic [tmk_pkg::MODE_W-1:0]         kick_mode_reg, kick_mode_next;
    logic [tmk_pkg::ORD_FIELD_W-1:0]    pole_power_reg, pole_power_next;
    logic [tmk_pkg::ORD_FIELD_W-1:0]    top_order_reg, top_order_next;
    logic                               cfg_wr;
    logic [1:0]                         cfg_idx;

    tmk_pkg::dp_cmd_t                   cmd;
    logic [IDX_W-1:0]                   coef_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_scale_reg <= '0;
            kick_mode_reg  <= tmk_pkg::MODE_DIPOLE;
            pole_power_reg <= tmk_pkg::ORD_FIELD_W'(1);
            top_order_reg  <= tmk_pkg::ORD_FIELD_W'(1);
        end else begin
            kick_scale_reg <= kick_scale_next;
            kick_mode_reg  <= kick_mode_next;
            pole_power_reg <= pole_power_next;
            top_order_reg  <= top_order_next;
        end
    end

    // register writes, low bits of the data word
    always_comb begin
        kick_scale_next = kick_scale_reg;
        kick_mode_next  = kick_mode_reg;
        pole_power_next = pole_power_reg;
        top_order_next  = top_order_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                tmk_pkg::REG_KICK_SCALE: kick_scale_next = pwdata;
                tmk_pkg::REG_KICK_MODE:  kick_mode_next  = pwdata[tmk_pkg::MODE_W-1:0];
                tmk_pkg::REG_POLE_POWER: pole_power_next = pwdata[tmk_pkg::ORD_FIELD_W-1:0];
                tmk_pkg::REG_TOP_ORDER:  top_order_next  = pwdata[tmk_pkg::ORD_FIELD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            tmk_pkg::REG_KICK_SCALE: prdata = kick_scale_reg;
            tmk_pkg::REG_KICK_MODE:  prdata = tmk_pkg::DATA_W'(kick_mode_reg);
            tmk_pkg::REG_POLE_POWER: prdata = tmk_pkg::DATA_W'(pole_power_reg);
            tmk_pkg::REG_TOP_ORDER:  prdata = tmk_pkg::DATA_W'(top_order_reg);
            default:                 prdata = '0;
        endcase
    end

    // sequencer
    tmk_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .kick_mode  (kick_mode_reg),
        .pole_power (pole_power_reg),
        .top_order  (top_order_reg),
        .scale_zero (kick_scale_reg == '0),
        .cmd        (cmd),
        .coef_sel   (coef_sel)
    );

    // arithmetic and coefficient table
    tmk_dp #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .coef_sel     (coef_sel),
        .kick_scale   (kick_scale_reg),
        .s_coef_index (s_coef_index),
        .s_coef_real  (s_coef_real),
        .s_coef_imag  (s_coef_imag),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_mom_x      (s_mom_x),
        .s_mom_y      (s_mom_y),
        .m_new_mom_x  (m_new_mom_x),
        .m_new_mom_y  (m_new_mom_y),
        .m_saturated  (m_saturated)
    );

    // a load request never produces a result
    `TMK_ASSERT_NEXT(a_load_no_result, aclk, aresetn, s_valid && s_ready && (s_req_type == tmk_pkg::REQ_LOAD) && !m_valid, !m_valid)

    // a kick request always makes the unit busy in the next cycle
    `TMK_ASSERT_IMPL(a_kick_goes_busy, aclk, aresetn, $past(aresetn) && $past(s_valid && s_ready && (s_req_type == tmk_pkg::REQ_KICK)), !s_ready)

    // zero scale passes the momenta through unflagged, going from accept straight to the done state
    `TMK_ASSERT_NEXT(a_zero_scale_pass, aclk, aresetn, $past(aresetn) && $past(s_valid && s_ready && (s_req_type == tmk_pkg::REQ_KICK) && (kick_scale_reg == '0) && !m_valid), m_valid && (m_new_mom_x == $past(s_mom_x, 2)) && (m_new_mom_y == $past(s_mom_y, 2)) && !m_saturated)

endmodule

`default_nettype wire
